>>> rtl/lra_pkg.sv
// Shared types, constants and register-number tables for the lifetime register allocator.
package lra_pkg;

   localparam int FIXED_VREGS = 7;
   localparam int SLOT_MAX    = 16;
   localparam int PHYS_W      = 4;

   typedef logic [PHYS_W-1:0] phys_type;

   typedef struct packed {
      logic claim;
      logic clr_busy;
      logic upd_expiry;
   } slot_cmd_type;

   typedef struct packed {
      logic busy;
      logic mine;
      logic expired;
   } slot_status_type;

   // RDI, RSI, RDX, RCX, R8, R9, RAX
   function automatic phys_type fixed_phys(input logic [2:0] vreg);
      phys_type p;
      case (vreg)
         3'd0: p = 4'd7 - 4'd2;
         3'd1: p = 4'd4;
         3'd2: p = 4'd2;
         3'd3: p = 4'd1;
         3'd4: p = 4'd8;
         3'd5: p = 4'd9;
         3'd6: p = 4'd0;
         default: p = 4'd0;
      endcase
      return p;
   endfunction

   // R15, R14, R13, R12, R11, R10, RBX, repeating every seven slots
   function automatic phys_type slot_phys(input logic [3:0] idx);
      phys_type p;
      case (idx)
         4'd0, 4'd7, 4'd14: p = 4'd15;
         4'd1, 4'd8, 4'd15: p = 4'd14;
         4'd2, 4'd9:        p = 4'd13;
         4'd3, 4'd10:       p = 4'd12;
         4'd4, 4'd11:       p = 4'd11;
         4'd5, 4'd12:       p = 4'd10;
         4'd6, 4'd13:       p = 4'd3;
         default:           p = 4'd0;
      endcase
      return p;
   endfunction

endpackage

>>> rtl/lra_req_if.sv
// Request channel: virtual register, end of live range and current time step.
interface lra_req_if #(
   parameter int VREG_BITS = 8,
   parameter int TIME_BITS = 16
);
   logic                 valid;
   logic                 ready;
   logic [VREG_BITS-1:0] virtual_reg;
   logic [TIME_BITS-1:0] range_end;
   logic [TIME_BITS-1:0] now;

   modport source (output valid, output virtual_reg, output range_end, output now,
                   input ready);
   modport sink   (input valid, input virtual_reg, input range_end, input now,
                   output ready);
endinterface

>>> rtl/lra_rsp_if.sv
// Response channel: physical register number and out-of-registers flag.
interface lra_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] phys_reg;
   logic       out_of_registers;

   modport source (output valid, output phys_reg, output out_of_registers, input ready);
   modport sink   (input valid, input phys_reg, input out_of_registers, output ready);
endinterface

>>> rtl/lra_slots.sv
// Slot file with the shared owner/expiry compare unit used by the scan.
module lra_slots
   import lra_pkg::*;
#(
   parameter int GP_SLOTS  = 7,
   parameter int VREG_BITS = 8,
   parameter int TIME_BITS = 16,
   parameter int IDX_W     = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [IDX_W-1:0]     rd_idx,
   input  logic [IDX_W-1:0]     wr_idx,
   input  slot_cmd_type         cmd,
   input  logic [VREG_BITS-1:0] vreg,
   input  logic [TIME_BITS-1:0] range_end,
   input  logic [TIME_BITS-1:0] now,
   output slot_status_type      status
);

   logic [GP_SLOTS-1:0]  busy_ff;
   logic [GP_SLOTS-1:0]  busy_in;
   logic [VREG_BITS-1:0] owner_ff  [GP_SLOTS];
   logic [TIME_BITS-1:0] expiry_ff [GP_SLOTS];
   logic [TIME_BITS-1:0] exp_sel;
   logic                 mine;

   always_comb begin
      mine           = (owner_ff[rd_idx] == vreg);
      exp_sel        = mine ? range_end : expiry_ff[rd_idx];
      status.busy    = busy_ff[rd_idx];
      status.mine    = mine;
      status.expired = (exp_sel < now);
   end

   always_comb begin
      busy_in = busy_ff;
      if (cmd.clr_busy) begin
         busy_in[rd_idx] = 1'b0;
      end
      if (cmd.claim) begin
         busy_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.upd_expiry) begin
         expiry_ff[rd_idx] <= range_end;
      end
      if (cmd.claim) begin
         owner_ff[wr_idx]  <= vreg;
         expiry_ff[wr_idx] <= range_end;
      end
   end

   a_clr_only_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_busy |-> status.busy)
      else $error("release of a free slot");

   a_claim_sets_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.claim |=> busy_ff[$past(wr_idx)])
      else $error("claimed slot not marked busy");

   a_claim_alone: assert property (@(posedge clock) disable iff (reset)
      cmd.claim |-> (!cmd.clr_busy && !cmd.upd_expiry))
      else $error("claim overlaps a scan update");

   a_upd_on_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.upd_expiry |-> (status.busy && status.mine && !status.expired))
      else $error("expiry update without a live hit");

endmodule

>>> rtl/lifetime_register_allocator.sv
// Top level: linear-scan register allocator with a one-slot-per-cycle scan sequencer.
//
//   channel  dir  fields                                  transaction
//   req_ch   in   virtual_reg, range_end, now             valid & ready
//   rsp_ch   out  phys_reg, out_of_registers              valid & ready
//
// A fixed virtual register (0 to 6) skips the scan and goes straight from accept to completion.
// Any other steps through each slot in turn via the shared compare unit, then claims,
// loads the response register and presents it; a hit stops the scan early and skips the claim.
// Reset clears every slot's busy mark; owners and expiries need no clearing.
// A new request is taken while the previous response waits; a stalled response
// holds the finished result until its register frees.
module lifetime_register_allocator
   import lra_pkg::*;
#(
   parameter int GP_SLOTS  = 7,
   parameter int VREG_BITS = 8,
   parameter int TIME_BITS = 16
) (
   input  logic   clock,
   input  logic   reset,
   lra_req_if.sink   req_ch,
   lra_rsp_if.source rsp_ch
);

   localparam int IDX_W = (GP_SLOTS > 1) ? $clog2(GP_SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GP_SLOTS - 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_CLAIM = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;
   logic                 free_found_ff, free_found_in;
   logic [VREG_BITS-1:0] vreg_ff, vreg_in;
   logic [TIME_BITS-1:0] end_ff, end_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   phys_type             res_phys_ff, res_phys_in;
   logic                 res_oor_ff, res_oor_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   phys_type             rsp_phys_ff, rsp_phys_in;
   logic                 rsp_oor_ff, rsp_oor_in;

   slot_cmd_type         cmd;
   slot_status_type      st;
   logic                 req_take;
   logic                 slot_free;

   lra_slots #(
      .GP_SLOTS  (GP_SLOTS),
      .VREG_BITS (VREG_BITS),
      .TIME_BITS (TIME_BITS),
      .IDX_W     (IDX_W)
   ) u_slots (
      .clock     (clock),
      .reset     (reset),
      .rd_idx    (idx_ff),
      .wr_idx    (free_idx_ff),
      .cmd       (cmd),
      .vreg      (vreg_ff),
      .range_end (end_ff),
      .now       (now_ff),
      .status    (st)
   );

   assign req_ch.ready            = (state_ff == ST_IDLE) && !reset;
   assign req_take                = req_ch.valid && (state_ff == ST_IDLE);
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.phys_reg         = rsp_phys_ff;
   assign rsp_ch.out_of_registers = rsp_oor_ff;
   assign slot_free               = !st.busy || st.expired;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      free_idx_in   = free_idx_ff;
      free_found_in = free_found_ff;
      vreg_in       = vreg_ff;
      end_in        = end_ff;
      now_in        = now_ff;
      res_phys_in   = res_phys_ff;
      res_oor_in    = res_oor_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_phys_in   = rsp_phys_ff;
      rsp_oor_in    = rsp_oor_ff;
      cmd           = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               vreg_in       = req_ch.virtual_reg;
               end_in        = req_ch.range_end;
               now_in        = req_ch.now;
               idx_in        = '0;
               free_found_in = 1'b0;
               if (req_ch.virtual_reg < VREG_BITS'(FIXED_VREGS)) begin
                  res_phys_in = fixed_phys(req_ch.virtual_reg[2:0]);
                  res_oor_in  = 1'b0;
                  state_in    = ST_DONE;
               end else begin
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.clr_busy = st.busy && st.expired;
            if (st.busy && !st.expired && st.mine) begin
               cmd.upd_expiry = 1'b1;
               res_phys_in    = slot_phys(4'(idx_ff));
               res_oor_in     = 1'b0;
               state_in       = ST_DONE;
            end else begin
               if (slot_free && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = idx_ff;
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_CLAIM;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_CLAIM: begin
            if (free_found_ff) begin
               cmd.claim   = 1'b1;
               res_phys_in = slot_phys(4'(free_idx_ff));
               res_oor_in  = 1'b0;
            end else begin
               res_phys_in = '0;
               res_oor_in  = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_phys_in  = res_phys_ff;
               rsp_oor_in   = res_oor_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         idx_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         free_found_ff <= free_found_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      free_idx_ff <= free_idx_in;
      vreg_ff     <= vreg_in;
      end_ff      <= end_in;
      now_ff      <= now_in;
      res_phys_ff <= res_phys_in;
      res_oor_ff  <= res_oor_in;
      rsp_phys_ff <= rsp_phys_in;
      rsp_oor_ff  <= rsp_oor_in;
   end

   a_oor_phys_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_oor_ff) |-> (rsp_phys_ff == '0))
      else $error("failed allocation carries a register number");

   a_fixed_direct: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_ch.virtual_reg < VREG_BITS'(FIXED_VREGS))) |=> (state_ff == ST_DONE))
      else $error("fixed register entered the scan");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside completion");

endmodule

>>> bench/lifetime_register_allocator_tb.sv
// Self-checking testbench for the lifetime register allocator: directed and random requests.
`timescale 1ns / 1ps

module lifetime_register_allocator_tb
   import lra_pkg::*;
();

   localparam int GP_SLOTS     = 7;
   localparam int VREG_BITS    = 8;
   localparam int TIME_BITS    = 16;
   localparam int MAX_WAIT     = 16;
   localparam int IDLE_LIMIT   = 1000;
   localparam int DRAIN_CYCLES = 32;
   localparam int TIME_MAX     = (1 << TIME_BITS) - 1;

   localparam phys_type PHYS_RAX = 4'd0;
   localparam phys_type PHYS_RCX = 4'd1;
   localparam phys_type PHYS_RDX = 4'd2;
   localparam phys_type PHYS_RBX = 4'd3;
   localparam phys_type PHYS_RSI = 4'd4;
   localparam phys_type PHYS_RDI = 4'd5;
   localparam phys_type PHYS_R8  = 4'd8;
   localparam phys_type PHYS_R9  = 4'd9;
   localparam phys_type PHYS_R10 = 4'd10;
   localparam phys_type PHYS_R11 = 4'd11;
   localparam phys_type PHYS_R12 = 4'd12;
   localparam phys_type PHYS_R13 = 4'd13;
   localparam phys_type PHYS_R14 = 4'd14;
   localparam phys_type PHYS_R15 = 4'd15;

   typedef logic [VREG_BITS-1:0] vreg_type;
   typedef logic [TIME_BITS-1:0] step_type;

   typedef struct packed {
      phys_type phys_reg;
      logic     out_of_registers;
   } allocation_type;

   logic clock = 1'b0;
   logic reset;

   lra_req_if #(.VREG_BITS(VREG_BITS), .TIME_BITS(TIME_BITS)) req_ch ();
   lra_rsp_if rsp_ch ();

   lifetime_register_allocator #(
      .GP_SLOTS (GP_SLOTS),
      .VREG_BITS(VREG_BITS),
      .TIME_BITS(TIME_BITS)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always #1 clock = ~clock;

   logic     slot_held [GP_SLOTS];
   vreg_type slot_vreg [GP_SLOTS];
   step_type slot_last [GP_SLOTS];

   allocation_type pending_allocations[$];
   allocation_type expected_alloc;
   int             error_count = 0;
   int             ready_hold = 0;
   int             stall_draw;
   int             idle_cycles = 0;
   logic           steady_flow = 1'b0;

   function automatic phys_type argument_register(input logic [2:0] v);
      case (v)
         3'd0:    return PHYS_RDI;
         3'd1:    return PHYS_RSI;
         3'd2:    return PHYS_RDX;
         3'd3:    return PHYS_RCX;
         3'd4:    return PHYS_R8;
         3'd5:    return PHYS_R9;
         default: return PHYS_RAX;
      endcase
   endfunction

   function automatic phys_type scratch_register(input int slot);
      case (slot % 7)
         0:       return PHYS_R15;
         1:       return PHYS_R14;
         2:       return PHYS_R13;
         3:       return PHYS_R12;
         4:       return PHYS_R11;
         5:       return PHYS_R10;
         default: return PHYS_RBX;
      endcase
   endfunction

   function automatic allocation_type allocate_register(input vreg_type v,
                                                        input step_type range_end,
                                                        input step_type now);
      allocation_type a;
      logic           mine;
      step_type       last;
      int             i;
      a.phys_reg = PHYS_RAX;
      a.out_of_registers = 1'b0;
      if (v < FIXED_VREGS) begin
         a.phys_reg = argument_register(v[2:0]);
         return a;
      end
      for (i = 0; i < GP_SLOTS; i++) begin
         if (slot_held[i]) begin
            mine = (slot_vreg[i] == v);
            last = mine ? range_end : slot_last[i];
            if (last < now) begin
               slot_held[i] = 1'b0;
            end else if (mine) begin
               slot_last[i] = range_end;
               a.phys_reg = scratch_register(i);
               return a;
            end
         end
      end
      for (i = 0; i < GP_SLOTS; i++) begin
         if (!slot_held[i]) begin
            slot_held[i] = 1'b1;
            slot_vreg[i] = v;
            slot_last[i] = range_end;
            a.phys_reg = scratch_register(i);
            return a;
         end
      end
      a.out_of_registers = 1'b1;
      return a;
   endfunction

   function automatic int draw_wait();
      return steady_flow ? 0 : int'($urandom_range(0, MAX_WAIT));
   endfunction

   task automatic send_request(input vreg_type v, input step_type range_end,
                               input step_type now);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.virtual_reg <= v;
      req_ch.range_end   <= range_end;
      req_ch.now         <= now;
      pending_allocations.push_back(allocate_register(v, range_end, now));
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic hold_request_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_for_results();
      hold_request_idle();
      while (pending_allocations.size() != 0) @(posedge clock);
   endtask

   task automatic test_fixed_registers();
      int v;
      for (v = 0; v < FIXED_VREGS; v++)
         send_request(vreg_type'(v), (v % 2) ? step_type'(TIME_MAX) : '0,
                      (v % 2) ? '0 : step_type'(TIME_MAX));
   endtask

   task automatic test_claim_until_exhausted();
      int v;
      for (v = 7; v < 7 + GP_SLOTS; v++)
         send_request(vreg_type'(v), 16'd200, 16'd100);
      send_request(8'd255, step_type'(TIME_MAX), 16'd100);
      send_request(8'd7, 16'd300, 16'd100);
   endtask

   task automatic test_expiry_and_hits();
      // release stale slots, then let an owner's own short range free its slot
      send_request(8'd14, step_type'(TIME_MAX), 16'd201);
      send_request(8'd7, 16'd150, 16'd201);
      send_request(8'd7, 16'd250, 16'd201);
      send_request(8'd14, step_type'(TIME_MAX), step_type'(TIME_MAX));
      send_request(8'd200, '0, '0);
   endtask

   task automatic test_random_live_ranges(input int segments, input int per_segment);
      step_type t;
      vreg_type v;
      int       e, s, k, pool_base, pool_size;
      for (s = 0; s < segments; s++) begin
         steady_flow = ($urandom_range(0, 4) == 0);
         t = step_type'($urandom_range(0, TIME_MAX));
         pool_base = $urandom_range(7, 240);
         pool_size = $urandom_range(4, 15);
         for (k = 0; k < per_segment; k++) begin
            if ($urandom_range(0, 9) == 0)
               v = vreg_type'($urandom_range(0, FIXED_VREGS - 1));
            else
               v = vreg_type'(pool_base + $urandom_range(0, pool_size - 1));
            if ($urandom_range(0, 15) == 0)
               e = int'(t) - int'($urandom_range(1, 8));
            else
               e = int'(t) + int'($urandom_range(0, 48));
            if (e < 0) e = 0;
            if (e > TIME_MAX) e = TIME_MAX;
            send_request(v, step_type'(e), t);
            if (int'(t) <= TIME_MAX - 3) t = t + step_type'($urandom_range(0, 3));
         end
         if ($urandom_range(0, 2) == 0) wait_for_results();
      end
   endtask

   task automatic test_noise(input int count);
      int k;
      for (k = 0; k < count; k++) begin
         if (k % 25 == 0) steady_flow = ($urandom_range(0, 3) == 0);
         send_request(vreg_type'($urandom), step_type'($urandom), step_type'($urandom));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         ready_hold   <= 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         if (pending_allocations.size() == 0) begin
            $error("response transaction with no request pending");
            error_count++;
         end else begin
            expected_alloc = pending_allocations.pop_front();
            if (rsp_ch.phys_reg !== expected_alloc.phys_reg) begin
               $error("phys_reg: expected %0d, got %0d", expected_alloc.phys_reg,
                      rsp_ch.phys_reg);
               error_count++;
            end
            if (rsp_ch.out_of_registers !== expected_alloc.out_of_registers) begin
               $error("out_of_registers: expected %0d, got %0d",
                      expected_alloc.out_of_registers, rsp_ch.out_of_registers);
               error_count++;
            end
         end
         stall_draw = draw_wait();
         if (stall_draw > 0) begin
            rsp_ch.ready <= 1'b0;
            ready_hold   <= stall_draw;
         end
      end else if (!rsp_ch.ready) begin
         if (ready_hold > 1)
            ready_hold <= ready_hold - 1;
         else
            rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.virtual_reg = '0;
      req_ch.range_end   = '0;
      req_ch.now         = '0;
      for (int i = 0; i < GP_SLOTS; i++) begin
         slot_held[i] = 1'b0;
         slot_vreg[i] = '0;
         slot_last[i] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_fixed_registers();
      test_claim_until_exhausted();
      test_expiry_and_hits();
      wait_for_results();
      test_random_live_ranges(14, 50);
      test_noise(125);
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> filelist.f
rtl/lra_pkg.sv
rtl/lra_req_if.sv
rtl/lra_rsp_if.sv
rtl/lra_slots.sv
rtl/lifetime_register_allocator.sv
bench/lifetime_register_allocator_tb.sv
